>>> rtl/core/cpu_utilization_monitor_defines.svh
// Assertion macros for the CPU utilisation monitor.
// Used by the top level only; no other dependencies.
`ifndef CPU_UTILIZATION_MONITOR_DEFINES_SVH
`define CPU_UTILIZATION_MONITOR_DEFINES_SVH
`ifndef SYNTH
`define CUM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cum assertion failed");
`define CUM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cum assertion failed");
`else
`define CUM_ASSERT_NOW(lbl, ante, cons)
`define CUM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/cum_pkg.sv
// Shared types and constants of the CPU utilisation monitor.
// No dependencies.
package cum_pkg;

  localparam int SLOT_W  = 8;
  localparam int FIELD_W = 48;
  localparam int PCT_W   = 15;
  localparam int SUM_W   = 23;
  localparam int CFG_W   = 15;

  localparam logic [SUM_W-1:0] SUM_LIMIT = 23'd6553600;

  // register indexes
  localparam logic REG_CPU_COUNT = 1'b0;
  localparam logic REG_SPARE     = 1'b1;

  // line kinds
  localparam logic REQ_SUMMARY = 1'b0;
  localparam logic REQ_CPU     = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CALC,
    S_PCT,
    S_FIN,
    S_SUM,
    S_EDGE1
  } state_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/cum_if.sv
// Request and result channel interfaces of the CPU utilisation monitor.
// Depends on cum_pkg for field widths.
interface cum_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [cum_pkg::SLOT_W-1:0]   cpu_slot;
  logic [cum_pkg::FIELD_W-1:0]  ticks_user;
  logic [cum_pkg::FIELD_W-1:0]  ticks_nice;
  logic [cum_pkg::FIELD_W-1:0]  ticks_system;
  logic [cum_pkg::FIELD_W-1:0]  ticks_idle;
  logic [cum_pkg::FIELD_W-1:0]  ticks_iowait;
  logic [cum_pkg::FIELD_W-1:0]  ticks_hardirq;
  logic [cum_pkg::FIELD_W-1:0]  ticks_softirq;
  logic [cum_pkg::FIELD_W-1:0]  ticks_steal;
  logic                         frame_end;

  modport source (output valid, req_type, cpu_slot, ticks_user, ticks_nice, ticks_system,
                  ticks_idle, ticks_iowait, ticks_hardirq, ticks_softirq, ticks_steal,
                  frame_end, input ready);
  modport sink (input valid, req_type, cpu_slot, ticks_user, ticks_nice, ticks_system,
                ticks_idle, ticks_iowait, ticks_hardirq, ticks_softirq, ticks_steal,
                frame_end, output ready);
endinterface

interface cum_out_if;
  logic                        valid;
  logic                        ready;
  logic [cum_pkg::SLOT_W-1:0]  cpu_slot_out;
  logic [cum_pkg::PCT_W-1:0]   busy_percent;
  logic                        frame_done;
  logic [cum_pkg::SUM_W-1:0]   frame_total_percent;
  logic                        over_threshold;
  logic                        alarm_first;

  modport source (output valid, cpu_slot_out, busy_percent, frame_done,
                  frame_total_percent, over_threshold, alarm_first, input ready);
  modport sink (input valid, cpu_slot_out, busy_percent, frame_done,
                frame_total_percent, over_threshold, alarm_first, output ready);
endinterface

>>> rtl/core/cum_mem.sv
// Per-CPU counter store: one row of eight counters per CPU, registered read.
// Clears itself after reset, one row a cycle. No package dependencies.
module cum_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 384
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic          clearing
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;

  // clearing pass sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/cum_div.sv
// Restoring divider, one quotient bit a cycle, shared by edge and percentage.
// Depends on cum_pkg for the status struct.
module cum_div #(
  parameter int W  = 52,
  parameter int CW = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [W-1:0]       rem_init,
  input  logic [W-1:0]       dvd_init,
  input  logic [W-1:0]       divisor,
  input  logic [CW-1:0]      iters,
  output logic [W-1:0]       quot,
  output cum_pkg::div_stat_t stat
);

  logic [W-1:0]  rem;
  logic [W-1:0]  dvd;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic [W-1:0]  trial;
  logic          fits;

  // shift in the next dividend bit and test the divisor
  always_comb begin
    trial = {rem[W-2:0], dvd[W-1]};
    fits  = (trial >= dsr);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
      cnt       <= iters;
    end else if (stat.busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  // datapath, quotient bits collect in the low end of dvd
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      dvd <= dvd_init;
      dsr <= divisor;
    end else if (stat.busy) begin
      rem <= fits ? (trial - dsr) : trial;
      dvd <= {dvd[W-2:0], fits};
    end
  end

  assign quot = dvd;

endmodule

>>> rtl/core/cpu_utilization_monitor.sv
// CPU utilisation monitor: per-CPU busy percent in Q7.8 from tick counters.
// Per-CPU line: store read, deltas, then a divider pass for the percentage (skipped when idle).
// Summary line: one pass of the shared divider.
// One line at a time, next request taken once the line ends; the divider sets the rate.
// Synchronous reset; the counter store then clears one row per CPU slot, requests held off.
`include "cpu_utilization_monitor_defines.svh"
// Top level; depends on cum_pkg, cum_if, cum_mem and cum_div.
module cpu_utilization_monitor #(
  parameter int MAX_CPUS     = 256,
  parameter int TICK_BITS    = 48,
  parameter int EDGE_PERCENT = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  cum_in_if.sink                     req,
  cum_out_if.source                  res,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [cum_pkg::CFG_W-1:0]  cfg_data
);

  localparam int SW       = (TICK_BITS < cum_pkg::FIELD_W) ? TICK_BITS : cum_pkg::FIELD_W;
  localparam int TW       = SW + 3;
  localparam int W        = TW + 1;
  localparam int NW       = TW + 15;
  localparam int CW       = $clog2(W + 1);
  localparam int AW       = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int EDGE_DIV = 100 / EDGE_PERCENT;

  cum_pkg::state_t state, state_next;

  // configuration
  logic [8:0]  cpu_count;
  logic [14:0] spare_percent;

  // line registers
  logic [SW-1:0]             cur [8];
  logic [cum_pkg::SLOT_W-1:0] line_slot;
  logic                      line_end;
  logic [AW-1:0]             line_addr;

  // machine state
  logic [TW-1:0]            prev_total;
  logic signed [W-1:0]      idle_edge;
  logic                     edge_neg;
  logic [cum_pkg::SUM_W-1:0] frame_sum;
  logic                     alarm_latched;

  // per-line working registers
  logic [TW-1:0]             tot_r;
  logic [TW-1:0]             busy_r;
  logic [cum_pkg::PCT_W-1:0] pct_r;

  // result register
  logic                      out_valid;
  logic [cum_pkg::SLOT_W-1:0] out_slot;
  logic [cum_pkg::PCT_W-1:0] out_pct;
  logic                      out_done;
  logic [cum_pkg::SUM_W-1:0] out_total;
  logic                      out_over;
  logic                      out_first;

  // memory and divider hookup
  logic                mem_rd_en;
  logic [AW-1:0]       mem_rd_addr;
  logic [8*SW-1:0]     mem_rd_data;
  logic                mem_wr_en;
  logic [8*SW-1:0]     mem_wr_data;
  logic                mem_clearing;
  logic                div_start;
  logic [W-1:0]        div_rem;
  logic [W-1:0]        div_dvd;
  logic [W-1:0]        div_dsr;
  logic [CW-1:0]       div_iters;
  logic [W-1:0]        div_quot;
  cum_pkg::div_stat_t  div_stat;

  // combinational datapath
  logic                req_acc;
  logic [8:0]          eff_count;
  logic [SW-1:0]       delta [8];
  logic [SW-1:0]       prev_k [8];
  logic [TW-1:0]       delta_tot;
  logic [TW-1:0]       delta_busy;
  logic [TW-1:0]       sum_tot;
  logic signed [W-1:0] diff;
  logic [W-1:0]        diff_mag;
  logic [NW-1:0]       num;
  logic                pct_go;
  logic                fin_ok;
  logic [cum_pkg::SUM_W:0]   sum_wide;
  logic [cum_pkg::SUM_W-1:0] sum_sat;
  logic [17:0]         thr_prod;
  logic signed [17:0]  thr;
  logic                over;

  assign req_acc   = req.valid && req.ready;
  assign eff_count = (cpu_count == 9'd0) ? 9'd1 : cpu_count;
  assign fin_ok    = !out_valid || res.ready;

  always_comb begin
    delta_tot  = '0;
    sum_tot    = '0;
    for (int k = 0; k < 8; k++) begin
      prev_k[k] = mem_rd_data[k*SW +: SW];
      delta[k]  = (cur[k] > prev_k[k]) ? (cur[k] - prev_k[k]) : '0;
      delta_tot = delta_tot + TW'(delta[k]);
      sum_tot   = sum_tot + TW'(cur[k]);
      mem_wr_data[k*SW +: SW] = cur[k];
    end
    // user, nice, system, hardirq, softirq
    delta_busy = TW'(delta[0]) + TW'(delta[1]) + TW'(delta[2]) + TW'(delta[5])
               + TW'(delta[6]);
    diff     = $signed({1'b0, sum_tot}) - $signed({1'b0, prev_total});
    diff_mag = diff[W-1] ? W'(-diff) : W'(diff);
    // busy * 25600 as shifts and adds
    num    = (NW'(busy_r) << 14) + (NW'(busy_r) << 13) + (NW'(busy_r) << 10);
    pct_go = ($signed({1'b0, tot_r}) >= idle_edge) && (tot_r != '0);
  end

  // frame sum, threshold and alarm
  always_comb begin
    sum_wide = {1'b0, frame_sum} + (cum_pkg::SUM_W + 1)'(pct_r);
    sum_sat  = (sum_wide > {1'b0, cum_pkg::SUM_LIMIT}) ? cum_pkg::SUM_LIMIT
                                                      : sum_wide[cum_pkg::SUM_W-1:0];
    thr_prod = 18'(eff_count) * 18'd100;
    thr      = $signed(thr_prod) - $signed({3'b0, spare_percent});
    over     = line_end && (thr[17] || ({2'b0, sum_sat} > {thr[16:0], 8'b0}));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cum_pkg::S_CLEAR: if (!mem_clearing) state_next = cum_pkg::S_IDLE;
      cum_pkg::S_IDLE: begin
        if (req_acc) begin
          state_next = (req.req_type == cum_pkg::REQ_SUMMARY) ? cum_pkg::S_SUM
                                                              : cum_pkg::S_READ;
        end
      end
      cum_pkg::S_READ:  state_next = cum_pkg::S_CALC;
      cum_pkg::S_CALC:  state_next = pct_go ? cum_pkg::S_PCT : cum_pkg::S_FIN;
      cum_pkg::S_PCT:   if (div_stat.done) state_next = cum_pkg::S_FIN;
      cum_pkg::S_FIN:   if (fin_ok) state_next = cum_pkg::S_IDLE;
      cum_pkg::S_SUM:   state_next = cum_pkg::S_EDGE1;
      cum_pkg::S_EDGE1: if (div_stat.done) state_next = cum_pkg::S_IDLE;
      default:          state_next = cum_pkg::S_IDLE;
    endcase
  end

  // state outputs: handshake, store and divider control
  // (d / count) / k equals d / (count * k), so the edge needs one divider pass
  always_comb begin
    req.ready   = (state == cum_pkg::S_IDLE);
    mem_rd_en   = 1'b0;
    mem_rd_addr = AW'(req.cpu_slot % MAX_CPUS);
    mem_wr_en   = 1'b0;
    div_start   = 1'b0;
    div_rem     = '0;
    div_dvd     = diff_mag;
    div_dsr     = W'(32'(eff_count) * EDGE_DIV);
    div_iters   = CW'(W);
    case (state)
      cum_pkg::S_IDLE: mem_rd_en = req_acc && (req.req_type == cum_pkg::REQ_CPU);
      // write back in the same cycle the old row is used; the next read comes later
      cum_pkg::S_READ: mem_wr_en = 1'b1;
      cum_pkg::S_CALC: begin
        div_start = pct_go;
        div_rem   = W'(num[NW-1:15]);
        div_dvd   = {num[14:0], {(W-15){1'b0}}};
        div_dsr   = W'(tot_r);
        div_iters = CW'(15);
      end
      cum_pkg::S_SUM: div_start = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cum_pkg::S_CLEAR;
      cpu_count     <= 9'd1;
      spare_percent <= '0;
      prev_total    <= '0;
      idle_edge     <= '0;
      frame_sum     <= '0;
      alarm_latched <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == cum_pkg::REG_CPU_COUNT) cpu_count <= cfg_data[8:0];
        else spare_percent <= cfg_data[14:0];
      end
      if (state == cum_pkg::S_FIN && fin_ok) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        cum_pkg::S_SUM: begin
          prev_total <= sum_tot;
          frame_sum  <= '0;
        end
        cum_pkg::S_EDGE1: begin
          if (div_stat.done) idle_edge <= edge_neg ? -$signed(div_quot) : $signed(div_quot);
        end
        cum_pkg::S_FIN: begin
          if (fin_ok) begin
            frame_sum     <= line_end ? '0 : sum_sat;
            alarm_latched <= alarm_latched || over;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      cur[0]    <= req.ticks_user[SW-1:0];
      cur[1]    <= req.ticks_nice[SW-1:0];
      cur[2]    <= req.ticks_system[SW-1:0];
      cur[3]    <= req.ticks_idle[SW-1:0];
      cur[4]    <= req.ticks_iowait[SW-1:0];
      cur[5]    <= req.ticks_hardirq[SW-1:0];
      cur[6]    <= req.ticks_softirq[SW-1:0];
      cur[7]    <= req.ticks_steal[SW-1:0];
      line_slot <= req.cpu_slot;
      line_end  <= req.frame_end;
      line_addr <= mem_rd_addr;
    end
    if (state == cum_pkg::S_SUM) edge_neg <= diff[W-1];
    if (state == cum_pkg::S_READ) begin
      tot_r  <= delta_tot;
      busy_r <= delta_busy;
    end
    if (state == cum_pkg::S_CALC) pct_r <= '0;
    if (state == cum_pkg::S_PCT && div_stat.done) pct_r <= div_quot[cum_pkg::PCT_W-1:0];
    if (state == cum_pkg::S_FIN && fin_ok) begin
      out_slot  <= line_slot;
      out_pct   <= pct_r;
      out_done  <= line_end;
      out_total <= sum_sat;
      out_over  <= over;
      out_first <= over && !alarm_latched;
    end
  end

  assign res.valid               = out_valid;
  assign res.cpu_slot_out        = out_slot;
  assign res.busy_percent        = out_pct;
  assign res.frame_done          = out_done;
  assign res.frame_total_percent = out_total;
  assign res.over_threshold      = out_over;
  assign res.alarm_first         = out_first;

  cum_mem #(
    .DEPTH (MAX_CPUS),
    .AW    (AW),
    .DW    (8 * SW)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .rd_data  (mem_rd_data),
    .wr_en    (mem_wr_en),
    .wr_addr  (line_addr),
    .wr_data  (mem_wr_data),
    .clearing (mem_clearing)
  );

  cum_div #(
    .W  (W),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .dvd_init (div_dvd),
    .divisor  (div_dsr),
    .iters    (div_iters),
    .quot     (div_quot),
    .stat     (div_stat)
  );

  // checks
  `CUM_ASSERT_NOW(a_no_req_in_clear, state == cum_pkg::S_CLEAR, !req.ready)
  `CUM_ASSERT_NOW(a_pct_range, out_valid, out_pct <= 15'd25600)
  `CUM_ASSERT_NOW(a_first_is_over, out_valid && out_first, out_over && out_done)
  `CUM_ASSERT_NEXT(a_alarm_sticks, alarm_latched, alarm_latched)

endmodule

>>> bench/tb_cpu_utilization_monitor.sv
// Self-checking bench for cpu_utilization_monitor: random and directed sample lines,
// busy percent and frame results predicted in-bench and compared per field.
// Depends on cum_pkg, cum_if and the monitor RTL.
`timescale 1ns / 1ps

module tb_cpu_utilization_monitor;

  typedef struct {
    logic                         req_type;
    logic [cum_pkg::SLOT_W-1:0]   slot;
    logic [cum_pkg::FIELD_W-1:0]  ticks [8];
    logic                         fend;
  } line_t;

  typedef struct {
    logic [cum_pkg::SLOT_W-1:0] slot;
    logic [cum_pkg::PCT_W-1:0]  pct;
    logic                       done;
    logic [cum_pkg::SUM_W-1:0]  total;
    logic                       over;
    logic                       first;
  } util_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = cum_pkg::REG_CPU_COUNT;
  logic [cum_pkg::CFG_W-1:0] cfg_data = '0;

  cum_in_if  req_ch();
  cum_out_if res_ch();

  cpu_utilization_monitor uut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .res(res_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [47:0] prev_ticks [256][8] = '{default: '{default: 48'd0}};
  logic [51:0] prev_total = '0;
  longint      edge_lvl = 0;
  logic [cum_pkg::SUM_W-1:0] run_sum = '0;
  logic        alarm_seen = 1'b0;
  int          n_cpus;
  int          spare;

  line_t pending_lines [$];
  util_t expected_util [$];
  int    send_idle_pct, recv_idle_pct;
  int    errors, cycles, lines_sent, results_seen, frames_over;
  bit    hold_send;

  // Work out the result of one accepted line, updating predictor state
  function automatic void predict_line(line_t ln);
    logic [63:0] d [8];
    logic [63:0] tot, busy, n, whole, rem;
    longint diff, cnt, thr;
    logic [31:0] pct;
    util_t r;
    cnt = (n_cpus == 0) ? 1 : n_cpus;
    if (ln.req_type == cum_pkg::REQ_SUMMARY) begin
      tot = 0;
      for (int k = 0; k < 8; k++) tot += ln.ticks[k];
      diff = longint'(tot) - longint'({12'd0, prev_total});
      edge_lvl = (diff / cnt) / 5;
      prev_total = tot[51:0];
      run_sum = '0;
      return;
    end
    tot = 0;
    for (int k = 0; k < 8; k++) begin
      d[k] = (ln.ticks[k] > prev_ticks[ln.slot][k]) ?
             64'(ln.ticks[k] - prev_ticks[ln.slot][k]) : 64'd0;
      tot += d[k];
      prev_ticks[ln.slot][k] = ln.ticks[k];
    end
    busy = d[0] + d[1] + d[2] + d[5] + d[6];
    pct = 0;
    if (longint'(tot) >= edge_lvl && tot > 0) begin
      n = busy * 100;
      whole = n / tot;
      rem = n % tot;
      pct = 32'(whole * 256 + (rem * 256) / tot);
    end
    run_sum = (32'(run_sum) + pct > 6553600) ? cum_pkg::SUM_LIMIT
                                             : cum_pkg::SUM_W'(32'(run_sum) + pct);
    r.slot = ln.slot; r.pct = pct[cum_pkg::PCT_W-1:0]; r.done = ln.fend;
    r.total = run_sum; r.over = 1'b0; r.first = 1'b0;
    if (ln.fend) begin
      thr = cnt * 100 - spare;
      if (longint'(run_sum) > thr * 256) begin
        r.over = 1'b1;
        frames_over++;
        if (!alarm_seen) begin
          r.first = 1'b1;
          alarm_seen = 1'b1;
        end
      end
      run_sum = '0;
    end
    expected_util.push_back(r);
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_line(pending_lines.pop_front());
        lines_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_lines.size() > 0 && !hold_send
            && $urandom_range(99) >= send_idle_pct) begin
          line_t nx;
          nx = pending_lines[0];
          req_ch.valid <= 1'b1;
          req_ch.req_type <= nx.req_type;
          req_ch.cpu_slot <= nx.slot;
          req_ch.ticks_user <= nx.ticks[0];
          req_ch.ticks_nice <= nx.ticks[1];
          req_ch.ticks_system <= nx.ticks[2];
          req_ch.ticks_idle <= nx.ticks[3];
          req_ch.ticks_iowait <= nx.ticks[4];
          req_ch.ticks_hardirq <= nx.ticks[5];
          req_ch.ticks_softirq <= nx.ticks[6];
          req_ch.ticks_steal <= nx.ticks[7];
          req_ch.frame_end <= nx.fend;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (expected_util.size() == 0) begin
          $error("result with nothing expected, slot %0d", res_ch.cpu_slot_out);
          errors++;
        end else begin
          util_t e;
          e = expected_util.pop_front();
          if (res_ch.cpu_slot_out !== e.slot) begin
            $error("cpu_slot_out exp %0d got %0d", e.slot, res_ch.cpu_slot_out); errors++;
          end
          if (res_ch.busy_percent !== e.pct) begin
            $error("busy_percent exp %0d got %0d", e.pct, res_ch.busy_percent); errors++;
          end
          if (res_ch.frame_done !== e.done) begin
            $error("frame_done exp %0d got %0d", e.done, res_ch.frame_done); errors++;
          end
          if (res_ch.frame_total_percent !== e.total) begin
            $error("frame_total_percent exp %0d got %0d", e.total,
                   res_ch.frame_total_percent); errors++;
          end
          if (res_ch.over_threshold !== e.over) begin
            $error("over_threshold exp %0d got %0d", e.over, res_ch.over_threshold); errors++;
          end
          if (res_ch.alarm_first !== e.first) begin
            $error("alarm_first exp %0d got %0d", e.first, res_ch.alarm_first); errors++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(65535)), $urandom()};
  endfunction

  // Tick value: mostly cumulative growth over the slot's last value
  function automatic logic [47:0] grow(logic [47:0] base, int mode);
    case (mode)
      0: return base + $urandom_range(5000);
      1: return base + $urandom_range(50);
      2: return rand48();
      default: return (base > 100) ? base - $urandom_range(100) : base;
    endcase
  endfunction

  logic [47:0] shadow [256][8];

  function automatic line_t make_line(logic rt, logic [7:0] sl, logic fe, int mode);
    line_t ln;
    ln.req_type = rt; ln.slot = sl; ln.fend = fe;
    for (int k = 0; k < 8; k++) begin
      ln.ticks[k] = grow(shadow[sl][k], ($urandom_range(9) == 0) ? 3 : mode);
      if (rt == cum_pkg::REQ_CPU) shadow[sl][k] = ln.ticks[k];
    end
    return ln;
  endfunction

  task automatic drain();
    while (pending_lines.size() != 0 || expected_util.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= cum_pkg::CFG_W'(val);
    if (idx == cum_pkg::REG_CPU_COUNT) n_cpus = val & 9'h1FF; else spare = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Queue one frame: summary then a run of cpu lines, the last flagged
  task automatic queue_frame(int ncpu, int mode);
    line_t ln;
    ln = make_line(cum_pkg::REQ_SUMMARY, 8'd0, 1'($urandom_range(1)), mode);
    for (int k = 0; k < 8; k++) ln.ticks[k] = $urandom_range(1) ? rand48() : 48'($urandom());
    pending_lines.push_back(ln);
    for (int c = 0; c < ncpu; c++)
      pending_lines.push_back(make_line(cum_pkg::REQ_CPU, ($urandom_range(3) == 0) ?
        8'($urandom_range(255)) : 8'(c), c == ncpu - 1, mode));
  endtask

  initial begin
    line_t ln;
    int cfg_set [6][2] = '{'{1, 0}, '{256, 0}, '{0, 25600}, '{4, 50}, '{511, 32767}, '{2, 150}};
    for (int s = 0; s < 256; s++)
      for (int k = 0; k < 8; k++) begin
        shadow[s][k] = '0;
      end
    n_cpus = 1; spare = 0; hold_send = 1'b0;
    send_idle_pct = 32; recv_idle_pct = 87;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, falling counters, idle-only, busy-only, summary edges
    ln = make_line(cum_pkg::REQ_CPU, 8'd0, 1'b0, 0);
    foreach (ln.ticks[k]) ln.ticks[k] = '1;
    pending_lines.push_back(ln);
    foreach (ln.ticks[k]) ln.ticks[k] = '0;
    ln.fend = 1'b1; pending_lines.push_back(ln);               // all falling -> empty total
    ln.slot = 8'd255; pending_lines.push_back(ln);              // zero total
    foreach (ln.ticks[k]) ln.ticks[k] = (k == 3) ? 48'd1000 : 48'd0;
    ln.fend = 1'b0; pending_lines.push_back(ln);               // fully idle
    foreach (ln.ticks[k]) ln.ticks[k] = (k == 3) ? 48'd1000 : 48'd7;
    ln.fend = 1'b1; pending_lines.push_back(ln);
    ln.req_type = cum_pkg::REQ_SUMMARY;
    foreach (ln.ticks[k]) ln.ticks[k] = '1;
    pending_lines.push_back(ln);                               // huge edge
    ln.req_type = cum_pkg::REQ_CPU; ln.slot = 8'd9;
    foreach (ln.ticks[k]) ln.ticks[k] = 48'd10;
    pending_lines.push_back(ln);                               // forced idle
    ln.req_type = cum_pkg::REQ_SUMMARY; ln.fend = 1'b0;
    foreach (ln.ticks[k]) ln.ticks[k] = '0;
    pending_lines.push_back(ln);                               // negative edge
    ln.req_type = cum_pkg::REQ_CPU; ln.slot = 8'd9;
    foreach (ln.ticks[k]) ln.ticks[k] = (k == 0 || k == 5 || k == 6) ? 48'h800000000000 : 48'd20;
    ln.fend = 1'b1; pending_lines.push_back(ln);
    foreach (shadow[s]) foreach (shadow[s][k]) shadow[s][k] = '1;
    drain();

    // Random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      write_reg(cum_pkg::REG_CPU_COUNT, cfg_set[p][0]);
      write_reg(cum_pkg::REG_SPARE, cfg_set[p][1]);
      if (p == 2) begin
        send_idle_pct = 87; recv_idle_pct = 32;
      end else if (p == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int f = 0; f < 12; f++) begin
        if ($urandom_range(7) == 0)
          pending_lines.push_back(make_line(1'($urandom_range(1)), 8'($urandom_range(255)),
                                            1'($urandom_range(1)), $urandom_range(2)));
        queue_frame($urandom_range(1, 16), $urandom_range(2));
        if (f == 6) begin
          hold_send = 1'b1;
          // hold requests until every expected result is in
          while (expected_util.size() != 0 || (req_ch.valid && !req_ch.ready)) @(posedge clk);
          hold_send = 1'b0;
        end
      end
      drain();
    end

    $display("Covered %0d lines, %0d results, %0d frames over threshold.",
             lines_sent, results_seen, frames_over);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
